// File: design/gait_phase_clock_sin_cos_defines.svh
// ----------------------------------------------------------------------------
// Gait phase clock assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef GAIT_PHASE_CLOCK_SIN_COS_DEFINES_SVH
`define GAIT_PHASE_CLOCK_SIN_COS_DEFINES_SVH

// same-cycle implication
`define GPC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gpc assertion failed");

// next-cycle implication
`define GPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gpc assertion failed");

`endif

// File: design/gpc_pkg.sv
// ----------------------------------------------------------------------------
// Gait phase clock package
// Register codes, fixed-point constants and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package gpc_pkg;

   localparam int unsigned CSR_ADDR_BITS = 5;

   typedef enum logic [2:0] {
      REG_CYCLE_PERIOD = 3'd0,
      REG_LEFT_OFFSET  = 3'd1,
      REG_RIGHT_OFFSET = 3'd2,
      REG_LEFT_DUTY    = 3'd3,
      REG_RIGHT_DUTY   = 3'd4
   } reg_index_type;

   localparam logic [31:0] CYCLE_PERIOD_RESET = 32'd65536;
   localparam logic [15:0] LEFT_OFFSET_RESET  = 16'd0;
   localparam logic [15:0] RIGHT_OFFSET_RESET = 16'd32768;
   localparam logic [16:0] DUTY_RESET         = 17'd32768;

   // trig pipeline depth in registers
   localparam int unsigned TRIG_LAT = 12;

   localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
   localparam logic [29:0] OCT_SPAN       = 30'h2000_0000;
   localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;

   // exact floor division for values below 2^30: v * ceil(2^k/d) >> k
   localparam int unsigned K72 = 37;
   localparam int unsigned K42 = 36;
   localparam int unsigned K20 = 35;
   localparam int unsigned K6  = 33;
   localparam int unsigned K56 = 36;
   localparam int unsigned K30 = 35;
   localparam int unsigned K12 = 34;
   localparam logic [31:0] M72 = 32'(((64'd1 << K72) + 64'd71) / 64'd72);
   localparam logic [31:0] M42 = 32'(((64'd1 << K42) + 64'd41) / 64'd42);
   localparam logic [31:0] M20 = 32'(((64'd1 << K20) + 64'd19) / 64'd20);
   localparam logic [31:0] M6  = 32'(((64'd1 << K6) + 64'd5) / 64'd6);
   localparam logic [31:0] M56 = 32'(((64'd1 << K56) + 64'd55) / 64'd56);
   localparam logic [31:0] M30 = 32'(((64'd1 << K30) + 64'd29) / 64'd30);
   localparam logic [31:0] M12 = 32'(((64'd1 << K12) + 64'd11) / 64'd12);

   function automatic logic [30:0] div_rcp(input logic [30:0] v, input logic [31:0] m,
                                           input int unsigned k);
      logic [63:0] p;
      p = {33'd0, v} * {32'd0, m};
      p = p >> k;
      return p[30:0];
   endfunction

   // Q1.30 product
   function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = {31'd0, a} * {31'd0, b};
      return p[60:30];
   endfunction

endpackage

// File: design/gpc_div_cell.sv
// ----------------------------------------------------------------------------
// Gait phase clock divider cell
// One restoring division step: shifts in one dividend bit, subtracts the
// period when it fits and shifts the quotient bit into the dividend word.
// ----------------------------------------------------------------------------
module gpc_div_cell #(
   parameter int unsigned NB = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic [31:0]   divisor,
   input  logic          in_vld,
   input  logic [31:0]   in_rem,
   input  logic [NB-1:0] in_num,
   output logic          out_vld,
   output logic [31:0]   out_rem,
   output logic [NB-1:0] out_num
);

   logic          vld_ff;
   logic [31:0]   rem_ff, rem_in;
   logic [NB-1:0] num_ff, num_in;
   logic [32:0]   trial;
   logic          fits;

   always_comb begin
      trial  = {in_rem, in_num[NB-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      num_in = {in_num[NB-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

   assign out_vld = vld_ff;
   assign out_rem = rem_ff;
   assign out_num = num_ff;

endmodule

// File: design/gpc_trig.sv
// ----------------------------------------------------------------------------
// Gait phase clock sine and cosine unit
// Octant fold, Q1.30 Taylor series in Horner form, amplitude rounding and
// quadrant mapping, one register after every multiply.
// ----------------------------------------------------------------------------
module gpc_trig import gpc_pkg::*; #(
   parameter int unsigned PHASE_BITS     = 16,
   parameter int unsigned AMPLITUDE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [PHASE_BITS-1:0] phase,
   output logic [15:0]           phase_q16,
   output logic signed [15:0]    sine,
   output logic signed [15:0]    cosine
);

   localparam int unsigned PB = PHASE_BITS;
   localparam int unsigned AB = AMPLITUDE_BITS;

   function automatic logic [15:0] to_amp(input logic [30:0] v);
      logic [63:0] w;
      logic [63:0] full;
      w    = (({33'd0, v} << (AB - 1)) + (64'd1 << 29)) >> 30;
      full = (64'd1 << (AB - 1)) - 64'd1;
      if (w > full) w = full;
      w = (w << 16) >> AB;
      return w[15:0];
   endfunction

   function automatic logic [15:0] enc(input logic [15:0] mag, input logic neg);
      return neg ? 16'(16'd0 - mag) : mag;
   endfunction

   // phase carried along all stages
   logic [15:0] ph_ff [TRIG_LAT];
   logic [2:0]  oct_ff [TRIG_LAT];
   logic [15:0] ph_in;
   logic [31:0] u_in;
   logic [29:0] r_ff, r_in;
   logic [29:0] x1_ff, x2s_ff, x3_ff, x4_ff, x5_ff, x6_ff, x7_ff, x8_ff, x9_ff;
   logic [29:0] sq3_ff, sq4_ff, sq5_ff, sq6_ff, sq7_ff, sq8_ff;
   logic [30:0] as3_ff, ac3_ff, ps4_ff, pc4_ff, as5_ff, ac5_ff, ps6_ff, pc6_ff;
   logic [30:0] as7_ff, ac7_ff, ps8_ff, pc8_ff, as9_ff, c9_ff, s10_ff, c10_ff;
   logic [59:0] prod1, prod2;
   logic [15:0] ms, mc;
   logic signed [15:0] sin_ff, sin_in, cos_ff, cos_in;

   always_comb begin
      u_in  = 32'(({phase, 32'd0}) >> PB);
      ph_in = 16'(({phase, 16'd0}) >> PB);
      r_in  = {1'b0, u_in[28:0]};
      if (u_in[29]) r_in = OCT_SPAN - r_in;
      prod1 = {30'd0, r_ff} * {30'd0, QUARTER_PI_Q30};
      prod2 = {30'd0, x1_ff} * {30'd0, x1_ff};
   end

   always_comb begin
      if (oct_ff[TRIG_LAT-2][0]) begin
         ms = to_amp(c10_ff);
         mc = to_amp(s10_ff);
      end else begin
         ms = to_amp(s10_ff);
         mc = to_amp(c10_ff);
      end
      case (oct_ff[TRIG_LAT-2][2:1])
         2'd0:    begin sin_in = enc(ms, 1'b0); cos_in = enc(mc, 1'b0); end
         2'd1:    begin sin_in = enc(mc, 1'b0); cos_in = enc(ms, 1'b1); end
         2'd2:    begin sin_in = enc(ms, 1'b1); cos_in = enc(mc, 1'b1); end
         default: begin sin_in = enc(mc, 1'b1); cos_in = enc(ms, 1'b0); end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff[0]  <= ph_in;
         oct_ff[0] <= u_in[31:29];
         for (int i = 1; i < TRIG_LAT; i++) begin
            ph_ff[i]  <= ph_ff[i-1];
            oct_ff[i] <= oct_ff[i-1];
         end
         r_ff   <= r_in;
         x1_ff  <= prod1[58:29];
         x2s_ff <= x1_ff;
         sq3_ff <= prod2[59:30];
         x3_ff  <= x2s_ff;
         as3_ff <= Q30_ONE - div_rcp({1'b0, sq3_ff}, M72, K72);
         ac3_ff <= Q30_ONE - div_rcp({1'b0, sq3_ff}, M56, K56);
         sq4_ff <= sq3_ff;
         x4_ff  <= x3_ff;
         ps4_ff <= mul_q30({1'b0, sq4_ff}, as3_ff);
         pc4_ff <= mul_q30({1'b0, sq4_ff}, ac3_ff);
         sq5_ff <= sq4_ff;
         x5_ff  <= x4_ff;
         as5_ff <= Q30_ONE - div_rcp(ps4_ff, M42, K42);
         ac5_ff <= Q30_ONE - div_rcp(pc4_ff, M30, K30);
         sq6_ff <= sq5_ff;
         x6_ff  <= x5_ff;
         ps6_ff <= mul_q30({1'b0, sq6_ff}, as5_ff);
         pc6_ff <= mul_q30({1'b0, sq6_ff}, ac5_ff);
         sq7_ff <= sq6_ff;
         x7_ff  <= x6_ff;
         as7_ff <= Q30_ONE - div_rcp(ps6_ff, M20, K20);
         ac7_ff <= Q30_ONE - div_rcp(pc6_ff, M12, K12);
         sq8_ff <= sq7_ff;
         x8_ff  <= x7_ff;
         ps8_ff <= mul_q30({1'b0, sq8_ff}, as7_ff);
         pc8_ff <= mul_q30({1'b0, sq8_ff}, ac7_ff);
         x9_ff  <= x8_ff;
         as9_ff <= Q30_ONE - div_rcp(ps8_ff, M6, K6);
         c9_ff  <= Q30_ONE - (pc8_ff >> 1);
         s10_ff <= mul_q30({1'b0, x9_ff}, as9_ff);
         c10_ff <= c9_ff;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign phase_q16 = ph_ff[TRIG_LAT-1];
   assign sine      = sin_ff;
   assign cosine    = cos_ff;

endmodule

// File: design/gait_phase_clock_sin_cos.sv
// Request to result: divider cell chain, registered leg phases, sine/cosine pipeline.
// Throughput: one request per cycle unless a stalled result holds it; a chain of
// one-bit divider cells and a pipelined sine/cosine unit per leg, all advancing together.
// A stalled result freezes the whole pipeline.
// Reset (synchronous): clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
// Gait phase clock with quadrature sine and cosine
// Phase = frac(time / period) plus per-leg offset, then sine and cosine.
// ----------------------------------------------------------------------------
`include "gait_phase_clock_sin_cos_defines.svh"

module gait_phase_clock_sin_cos import gpc_pkg::*; #(
   parameter int unsigned PHASE_BITS     = 16,
   parameter int unsigned AMPLITUDE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [31:0]              req_time_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [15:0]              rsp_left_phase,
   output logic [15:0]              rsp_right_phase,
   output logic signed [15:0]       rsp_left_sine,
   output logic signed [15:0]       rsp_right_sine,
   output logic signed [15:0]       rsp_left_cosine,
   output logic signed [15:0]       rsp_right_cosine,
   output logic [16:0]              rsp_left_duty_out,
   output logic [16:0]              rsp_right_duty_out,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int unsigned PB = PHASE_BITS;
   localparam int unsigned NB = 32 + PB;

   logic [31:0] period_ff;
   logic [15:0] loff_ff, roff_ff;
   logic [16:0] lduty_ff, rduty_ff;
   logic        wr;
   logic        adv;
   logic [31:0] divisor;
   reg_index_type ridx;

   assign ridx       = reg_index_type'(csr_paddr[4:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= CYCLE_PERIOD_RESET;
         loff_ff   <= LEFT_OFFSET_RESET;
         roff_ff   <= RIGHT_OFFSET_RESET;
         lduty_ff  <= DUTY_RESET;
         rduty_ff  <= DUTY_RESET;
      end else if (wr) begin
         case (ridx)
            REG_CYCLE_PERIOD: period_ff <= csr_pwdata;
            REG_LEFT_OFFSET:  loff_ff   <= csr_pwdata[15:0];
            REG_RIGHT_OFFSET: roff_ff   <= csr_pwdata[15:0];
            REG_LEFT_DUTY:    lduty_ff  <= csr_pwdata[16:0];
            REG_RIGHT_DUTY:   rduty_ff  <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_CYCLE_PERIOD: csr_prdata = period_ff;
         REG_LEFT_OFFSET:  csr_prdata = {16'd0, loff_ff};
         REG_RIGHT_OFFSET: csr_prdata = {16'd0, roff_ff};
         REG_LEFT_DUTY:    csr_prdata = {15'd0, lduty_ff};
         REG_RIGHT_DUTY:   csr_prdata = {15'd0, rduty_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign divisor   = (period_ff == 32'd0) ? 32'd1 : period_ff;

   // divider chain: dividend is time << PHASE_BITS, low quotient bits are the phase
   logic          dv_vld [NB+1];
   logic [31:0]   dv_rem [NB+1];
   logic [NB-1:0] dv_num [NB+1];

   assign dv_vld[0] = req_valid && adv;
   assign dv_rem[0] = 32'd0;
   assign dv_num[0] = {req_time_value, PB'(0)};

   for (genvar g = 0; g < NB; g++) begin : g_div
      gpc_div_cell #(.NB(NB)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .divisor (divisor),
         .in_vld  (dv_vld[g]),
         .in_rem  (dv_rem[g]),
         .in_num  (dv_num[g]),
         .out_vld (dv_vld[g+1]),
         .out_rem (dv_rem[g+1]),
         .out_num (dv_num[g+1])
      );
   end

   logic [PB-1:0] base, loff_al, roff_al;
   logic [PB-1:0] lph_ff, lph_in, rph_ff, rph_in;
   logic          ph_vld_ff;
   logic [TRIG_LAT-1:0] tv_ff;

   always_comb begin
      base    = dv_num[NB][PB-1:0];
      loff_al = PB'(({loff_ff, PB'(0)}) >> 16);
      roff_al = PB'(({roff_ff, PB'(0)}) >> 16);
      lph_in  = base + loff_al;
      rph_in  = base + roff_al;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_vld_ff <= 1'b0;
         tv_ff     <= '0;
      end else if (adv) begin
         ph_vld_ff <= dv_vld[NB];
         tv_ff     <= {tv_ff[TRIG_LAT-2:0], ph_vld_ff};
      end
      if (adv) begin
         lph_ff <= lph_in;
         rph_ff <= rph_in;
      end
   end

   gpc_trig #(.PHASE_BITS(PB), .AMPLITUDE_BITS(AMPLITUDE_BITS)) u_left (
      .clock     (clock),
      .en        (adv),
      .phase     (lph_ff),
      .phase_q16 (rsp_left_phase),
      .sine      (rsp_left_sine),
      .cosine    (rsp_left_cosine)
   );

   gpc_trig #(.PHASE_BITS(PB), .AMPLITUDE_BITS(AMPLITUDE_BITS)) u_right (
      .clock     (clock),
      .en        (adv),
      .phase     (rph_ff),
      .phase_q16 (rsp_right_phase),
      .sine      (rsp_right_sine),
      .cosine    (rsp_right_cosine)
   );

   assign rsp_valid          = tv_ff[TRIG_LAT-1];
   assign rsp_left_duty_out  = lduty_ff;
   assign rsp_right_duty_out = rduty_ff;

   `GPC_ASSERT_NEXT(a_freeze, rsp_valid && rsp_stall, $stable(tv_ff) && $stable(ph_vld_ff))
   `GPC_ASSERT_NEXT(a_leg_gap, adv && dv_vld[NB], PB'(lph_ff - rph_ff) == $past(PB'(loff_al - roff_al)))
   `GPC_ASSERT_NOW(a_sin_upper, rsp_valid && rsp_left_phase[15], rsp_left_sine <= 16'sd0)
   `GPC_ASSERT_NOW(a_sin_lower, rsp_valid && !rsp_left_phase[15], rsp_left_sine >= 16'sd0)

endmodule
